### rtl/core/bhpq_pkg.sv
// Shared constants, codes and interface structs of the binary heap priority queue.
package bhpq_pkg;

    localparam int CAPACITY = 1024;
    localparam int KEY_W    = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_UPDATE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_EMPTY    = 2'd2,
        STATUS_BAD_SLOT = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_LD,
        ST_UP,
        ST_DN_L,
        ST_DN_R,
        ST_DN_C,
        ST_WRM,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [KEY_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic [KEY_W-1:0] a;
        logic [KEY_W-1:0] b;
    } cmp_req_t;

    // Slot s (1-based) lives at RAM address s-1.
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [CNT_W-1:0] s);
        logic [CNT_W-1:0] t;
        t = s - CNT_W'(1);
        return t[ADDR_W-1:0];
    endfunction

endpackage

### rtl/core/bhpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/bhpq_cmp.sv
// Shared priority comparator: a beats b under the selected heap order.
module bhpq_cmp (
    input  logic               min_order,
    input  bhpq_pkg::cmp_req_t req,
    output logic               beats
);

    always_comb
    begin
        if (min_order)
        begin
            beats = req.a < req.b;
        end
        else
        begin
            beats = req.a > req.b;
        end
    end

endmodule

### rtl/core/bhpq_ctrl.sv
// Heap sequencer: command decode, sift-up and sift-down walks, count and result registers.
module bhpq_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [1:0]                    mode,
    input  logic [bhpq_pkg::KEY_W-1:0]    key_value,
    input  logic [bhpq_pkg::CNT_W-1:0]    slot_index,
    input  logic [bhpq_pkg::KEY_W-1:0]    rdata,
    input  logic                          beats,
    output bhpq_pkg::mem_req_t            mem,
    output bhpq_pkg::cmp_req_t            cmp,
    output logic                          busy,
    output logic                          done,
    output logic [bhpq_pkg::KEY_W-1:0]    popped_value,
    output logic [bhpq_pkg::KEY_W-1:0]    top_value,
    output logic                          not_empty,
    output logic [bhpq_pkg::CNT_W-1:0]    entry_count,
    output logic [1:0]                    status
);

    localparam int CW = bhpq_pkg::CNT_W;
    localparam int KW = bhpq_pkg::KEY_W;

    bhpq_pkg::state_t  state_reg, state_next;
    bhpq_pkg::status_t status_reg, status_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [CW-1:0]     kid_pos_reg, kid_pos_next;
    logic [KW-1:0]     mov_reg, mov_next;
    logic [KW-1:0]     kid_key_reg, kid_key_next;
    logic [KW-1:0]     popped_reg, popped_next;
    logic [KW-1:0]     top_reg;
    logic              upd_reg, upd_next;
    logic              done_reg, done_next;

    logic [CW:0]       pos_x2;
    logic [CW:0]       kid_x2;
    logic [CW-1:0]     cnt_inc;
    logic [CW-1:0]     parent;

    assign pos_x2  = {pos_reg, 1'b0};
    assign kid_x2  = {kid_pos_reg, 1'b0};
    assign cnt_inc = cnt_reg + CW'(1);
    assign parent  = pos_reg >> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bhpq_pkg::ST_IDLE;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
            upd_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
            upd_reg    <= upd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        kid_pos_reg <= kid_pos_next;
        mov_reg     <= mov_next;
        kid_key_reg <= kid_key_next;
        popped_reg  <= popped_next;
        status_reg  <= status_next;
        // slot 1 is mirrored so pop and the result need no extra read
        if (mem.we && mem.waddr == bhpq_pkg::slot_addr(CW'(1)))
        begin
            top_reg <= mem.wdata;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        kid_pos_next = kid_pos_reg;
        mov_next     = mov_reg;
        kid_key_next = kid_key_reg;
        popped_next  = popped_reg;
        status_next  = status_reg;
        upd_next     = upd_reg;
        done_next    = 1'b0;
        mem.we       = 1'b0;
        mem.waddr    = bhpq_pkg::slot_addr(pos_reg);
        mem.wdata    = mov_reg;
        mem.raddr    = '0;
        cmp.a        = mov_reg;
        cmp.b        = rdata;

        unique case (state_reg)
            bhpq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    popped_next = '0;
                    status_next = bhpq_pkg::STATUS_OK;
                    upd_next    = 1'b0;
                    unique case (mode)
                        bhpq_pkg::MODE_PUSH:
                        begin
                            if (cnt_reg == CW'(bhpq_pkg::CAPACITY))
                            begin
                                status_next = bhpq_pkg::STATUS_FULL;
                                state_next  = bhpq_pkg::ST_FIN;
                            end
                            else
                            begin
                                cnt_next = cnt_inc;
                                mov_next = key_value;
                                pos_next = cnt_inc;
                                if (cnt_reg == '0)
                                begin
                                    state_next = bhpq_pkg::ST_WRM;
                                end
                                else
                                begin
                                    mem.raddr  = bhpq_pkg::slot_addr(cnt_inc >> 1);
                                    state_next = bhpq_pkg::ST_UP;
                                end
                            end
                        end
                        bhpq_pkg::MODE_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = bhpq_pkg::STATUS_EMPTY;
                                state_next  = bhpq_pkg::ST_FIN;
                            end
                            else
                            begin
                                popped_next = top_reg;
                                cnt_next    = cnt_reg - CW'(1);
                                if (cnt_reg == CW'(1))
                                begin
                                    state_next = bhpq_pkg::ST_FIN;
                                end
                                else
                                begin
                                    // fetch the last entry; it moves to the root
                                    mem.raddr  = bhpq_pkg::slot_addr(cnt_reg);
                                    state_next = bhpq_pkg::ST_POP_LD;
                                end
                            end
                        end
                        bhpq_pkg::MODE_UPDATE:
                        begin
                            if (slot_index == '0 || slot_index > cnt_reg)
                            begin
                                status_next = bhpq_pkg::STATUS_BAD_SLOT;
                                state_next  = bhpq_pkg::ST_FIN;
                            end
                            else
                            begin
                                mov_next = key_value;
                                pos_next = slot_index;
                                if (slot_index == CW'(1))
                                begin
                                    if (cnt_reg >= CW'(2))
                                    begin
                                        mem.raddr  = bhpq_pkg::slot_addr(CW'(2));
                                        state_next = bhpq_pkg::ST_DN_L;
                                    end
                                    else
                                    begin
                                        state_next = bhpq_pkg::ST_WRM;
                                    end
                                end
                                else
                                begin
                                    // first parent compare decides up or down
                                    upd_next   = 1'b1;
                                    mem.raddr  = bhpq_pkg::slot_addr(slot_index >> 1);
                                    state_next = bhpq_pkg::ST_UP;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = bhpq_pkg::ST_FIN;
                        end
                    endcase
                end
            end
            bhpq_pkg::ST_POP_LD:
            begin
                mov_next = rdata;
                pos_next = CW'(1);
                if (cnt_reg >= CW'(2))
                begin
                    mem.raddr  = bhpq_pkg::slot_addr(CW'(2));
                    state_next = bhpq_pkg::ST_DN_L;
                end
                else
                begin
                    state_next = bhpq_pkg::ST_WRM;
                end
            end
            bhpq_pkg::ST_UP:
            begin
                cmp.a = mov_reg;
                cmp.b = rdata;
                if (beats)
                begin
                    mem.we    = 1'b1;
                    mem.wdata = rdata;
                    pos_next  = parent;
                    upd_next  = 1'b0;
                    if (parent == CW'(1))
                    begin
                        state_next = bhpq_pkg::ST_WRM;
                    end
                    else
                    begin
                        mem.raddr = bhpq_pkg::slot_addr(parent >> 1);
                    end
                end
                else if (upd_reg && pos_x2 <= {1'b0, cnt_reg})
                begin
                    upd_next   = 1'b0;
                    mem.raddr  = bhpq_pkg::slot_addr(pos_x2[CW-1:0]);
                    state_next = bhpq_pkg::ST_DN_L;
                end
                else
                begin
                    mem.we     = 1'b1;
                    upd_next   = 1'b0;
                    done_next  = 1'b1;
                    state_next = bhpq_pkg::ST_IDLE;
                end
            end
            bhpq_pkg::ST_DN_L:
            begin
                kid_key_next = rdata;
                kid_pos_next = pos_x2[CW-1:0];
                if (pos_x2 < {1'b0, cnt_reg})
                begin
                    mem.raddr  = bhpq_pkg::slot_addr(pos_x2[CW-1:0] + CW'(1));
                    state_next = bhpq_pkg::ST_DN_R;
                end
                else
                begin
                    state_next = bhpq_pkg::ST_DN_C;
                end
            end
            bhpq_pkg::ST_DN_R:
            begin
                // right child wins only when strictly better
                cmp.a = rdata;
                cmp.b = kid_key_reg;
                if (beats)
                begin
                    kid_key_next = rdata;
                    kid_pos_next = kid_pos_reg + CW'(1);
                end
                state_next = bhpq_pkg::ST_DN_C;
            end
            bhpq_pkg::ST_DN_C:
            begin
                cmp.a = kid_key_reg;
                cmp.b = mov_reg;
                mem.we = 1'b1;
                if (beats)
                begin
                    mem.wdata = kid_key_reg;
                    pos_next  = kid_pos_reg;
                    if (kid_x2 <= {1'b0, cnt_reg})
                    begin
                        mem.raddr  = bhpq_pkg::slot_addr(kid_x2[CW-1:0]);
                        state_next = bhpq_pkg::ST_DN_L;
                    end
                    else
                    begin
                        state_next = bhpq_pkg::ST_WRM;
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = bhpq_pkg::ST_IDLE;
                end
            end
            bhpq_pkg::ST_WRM:
            begin
                mem.we     = 1'b1;
                done_next  = 1'b1;
                state_next = bhpq_pkg::ST_IDLE;
            end
            bhpq_pkg::ST_FIN:
            begin
                // requests answered without a heap walk still hold off the next one
                done_next  = 1'b1;
                state_next = bhpq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bhpq_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy         = state_reg != bhpq_pkg::ST_IDLE;
    assign done         = done_reg;
    assign popped_value = popped_reg;
    assign not_empty    = cnt_reg != '0;
    assign top_value    = (cnt_reg != '0) ? top_reg : '0;
    assign entry_count  = cnt_reg;
    assign status       = status_reg;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(bhpq_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == bhpq_pkg::ST_IDLE)
        else $error("result strobe while sequencer busy");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem.we |-> (pos_reg != '0 && pos_reg <= cnt_reg))
        else $error("heap write outside occupied slots");

    a_error_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != bhpq_pkg::STATUS_OK) |-> $stable(cnt_reg))
        else $error("rejected request changed the count");
`endif

endmodule

### rtl/core/binary_heap_priority_queue.sv
// Top level of the binary heap priority queue: config register, sequencer, comparator, RAM.
//
//   channel   signals                                   handshake
//   request   mode, key_value, slot_index               start while !busy
//   result    popped_value, top_value, not_empty,       done, one cycle
//             entry_count, status
//   config    cfg_data (min_order)                      cfg_we
//
// busy stays high after the accepting edge while the sequencer walks: a push visits
// ST_UP once per sift-up level plus the final write, and a pop or an update passes
// ST_DN_L, ST_DN_R (when a right child exists) and ST_DN_C per sift-down level; the walk
// is serial because of the single RAM read port and the shared comparator. Errors, the
// unused mode and a pop of the last entry pass through ST_FIN only. done is high in the
// first cycle in which busy is low; a new request may be accepted at the edge that ends the done cycle.
// Reset clears the count and sets min order; the heap RAM is not cleared.
// The receiver cannot stall results.
module binary_heap_priority_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [1:0]                 mode,
    input  logic [bhpq_pkg::KEY_W-1:0] key_value,
    input  logic [bhpq_pkg::CNT_W-1:0] slot_index,
    output logic                       busy,
    output logic                       done,
    output logic [bhpq_pkg::KEY_W-1:0] popped_value,
    output logic [bhpq_pkg::KEY_W-1:0] top_value,
    output logic                       not_empty,
    output logic [bhpq_pkg::CNT_W-1:0] entry_count,
    output logic [1:0]                 status,
    input  logic                       cfg_we,
    input  logic                       cfg_data
);

    logic                       min_order_reg;
    bhpq_pkg::mem_req_t         mem;
    bhpq_pkg::cmp_req_t         cmp;
    logic [bhpq_pkg::KEY_W-1:0] rdata;
    logic                       beats;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_order_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            min_order_reg <= cfg_data;
        end
    end

    bhpq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .mode         (mode),
        .key_value    (key_value),
        .slot_index   (slot_index),
        .rdata        (rdata),
        .beats        (beats),
        .mem          (mem),
        .cmp          (cmp),
        .busy         (busy),
        .done         (done),
        .popped_value (popped_value),
        .top_value    (top_value),
        .not_empty    (not_empty),
        .entry_count  (entry_count),
        .status       (status)
    );

    bhpq_cmp u_cmp (
        .min_order (min_order_reg),
        .req       (cmp),
        .beats     (beats)
    );

    bhpq_ram #(
        .WIDTH (bhpq_pkg::KEY_W),
        .DEPTH (bhpq_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .raddr (mem.raddr),
        .rdata (rdata)
    );

endmodule

### test/tb_binary_heap_priority_queue.sv
// Self-checking testbench of the binary heap priority queue: queued requests, predictor, checker.
module tb_binary_heap_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         TAIL_CYCLES = 40;

    typedef struct {
        logic [1:0]                 op;
        logic [bhpq_pkg::KEY_W-1:0] key;
        logic [bhpq_pkg::CNT_W-1:0] slot;
    } heap_req_t;

    typedef struct {
        logic [bhpq_pkg::KEY_W-1:0] popped;
        logic [bhpq_pkg::KEY_W-1:0] top;
        logic                       nonempty;
        logic [bhpq_pkg::CNT_W-1:0] count;
        bhpq_pkg::status_t          st;
    } heap_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic [1:0]                 mode = MODE_UNUSED;
    logic [bhpq_pkg::KEY_W-1:0] key_value = '0;
    logic [bhpq_pkg::CNT_W-1:0] slot_index = '0;
    logic                       busy;
    logic                       done;
    logic [bhpq_pkg::KEY_W-1:0] popped_value;
    logic [bhpq_pkg::KEY_W-1:0] top_value;
    logic                       not_empty;
    logic [bhpq_pkg::CNT_W-1:0] entry_count;
    logic [1:0]                 status;
    logic                       cfg_we = 1'b0;
    logic                       cfg_data = 1'b1;

    binary_heap_priority_queue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .mode         (mode),
        .key_value    (key_value),
        .slot_index   (slot_index),
        .busy         (busy),
        .done         (done),
        .popped_value (popped_value),
        .top_value    (top_value),
        .not_empty    (not_empty),
        .entry_count  (entry_count),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // ---------------- heap predictor ----------------
    logic [bhpq_pkg::KEY_W-1:0] heap_mem [1:bhpq_pkg::CAPACITY];
    int unsigned                heap_cnt  = 0;
    bit                         order_min = 1'b1;

    function automatic bit key_wins(logic [bhpq_pkg::KEY_W-1:0] a,
                                    logic [bhpq_pkg::KEY_W-1:0] b);
        return order_min ? (a < b) : (a > b);
    endfunction

    function automatic void swap_keys(int unsigned a, int unsigned b);
        logic [bhpq_pkg::KEY_W-1:0] t;
        t           = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = t;
    endfunction

    function automatic void heap_sift_up(int unsigned pos);
        int unsigned p;
        p = pos;
        while (p > 1 && key_wins(heap_mem[p], heap_mem[p / 2]))
        begin
            swap_keys(p, p / 2);
            p = p / 2;
        end
    endfunction

    function automatic void heap_sift_down(int unsigned pos);
        int unsigned p;
        int unsigned kid;
        p = pos;
        while (2 * p <= heap_cnt)
        begin
            kid = 2 * p;
            // right child only when strictly better
            if (kid + 1 <= heap_cnt && key_wins(heap_mem[kid + 1], heap_mem[kid]))
                kid = kid + 1;
            if (!key_wins(heap_mem[kid], heap_mem[p]))
                break;
            swap_keys(p, kid);
            p = kid;
        end
    endfunction

    function automatic heap_result_t heap_apply(heap_req_t r);
        heap_result_t res;
        int unsigned  s;
        res.popped = '0;
        res.st     = bhpq_pkg::STATUS_OK;
        s          = r.slot;
        case (r.op)
            bhpq_pkg::MODE_PUSH:
            begin
                if (heap_cnt >= bhpq_pkg::CAPACITY)
                    res.st = bhpq_pkg::STATUS_FULL;
                else
                begin
                    heap_cnt++;
                    heap_mem[heap_cnt] = r.key;
                    heap_sift_up(heap_cnt);
                end
            end
            bhpq_pkg::MODE_POP:
            begin
                if (heap_cnt == 0)
                    res.st = bhpq_pkg::STATUS_EMPTY;
                else
                begin
                    res.popped  = heap_mem[1];
                    heap_mem[1] = heap_mem[heap_cnt];
                    heap_cnt--;
                    if (heap_cnt > 0)
                        heap_sift_down(1);
                end
            end
            bhpq_pkg::MODE_UPDATE:
            begin
                if (s == 0 || s > heap_cnt)
                    res.st = bhpq_pkg::STATUS_BAD_SLOT;
                else
                begin
                    heap_mem[s] = r.key;
                    if (s == 1)
                        heap_sift_down(1);
                    else if (2 * s > heap_cnt)
                        heap_sift_up(s);
                    else if (key_wins(heap_mem[s], heap_mem[s / 2]))
                        heap_sift_up(s);
                    else
                        heap_sift_down(s);
                end
            end
            default: ;
        endcase
        res.top      = (heap_cnt > 0) ? heap_mem[1] : '0;
        res.nonempty = (heap_cnt > 0);
        res.count    = bhpq_pkg::CNT_W'(heap_cnt);
        return res;
    endfunction

    // ---------------- driver ----------------
    heap_req_t    req_pending [$];
    heap_result_t heap_expect [$];
    heap_req_t    req_cur;
    int unsigned  idle_pct = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            mode       <= MODE_UNUSED;
            key_value  <= '0;
            slot_index <= '0;
        end
        else
        begin
            if (start && !busy)
                heap_expect.insert(heap_expect.size(), heap_apply(req_cur));
            if (!start || !busy)
            begin
                if (req_pending.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    req_cur     = req_pending.pop_front();
                    start      <= 1'b1;
                    mode       <= req_cur.op;
                    key_value  <= req_cur.key;
                    slot_index <= req_cur.slot;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    int mismatch_cnt = 0;

    function automatic void check_field(string what, logic [bhpq_pkg::KEY_W-1:0] want,
                                        logic [bhpq_pkg::KEY_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge clk)
    begin
        heap_result_t e;
        if (rst_n && done)
        begin
            if (heap_expect.size() == 0)
            begin
                $display("%0t: result with no request waiting: expected none, got top %h",
                         $time, top_value);
                mismatch_cnt++;
            end
            else
            begin
                e = heap_expect.pop_front();
                check_field("popped_value", e.popped, popped_value);
                check_field("top_value", e.top, top_value);
                check_field("not_empty", bhpq_pkg::KEY_W'(e.nonempty),
                            bhpq_pkg::KEY_W'(not_empty));
                check_field("entry_count", bhpq_pkg::KEY_W'(e.count),
                            bhpq_pkg::KEY_W'(entry_count));
                check_field("status", bhpq_pkg::KEY_W'(e.st), bhpq_pkg::KEY_W'(status));
            end
        end
    end

    // ---------------- stimulus ----------------
    int unsigned gen_cnt = 0;   // entry count as seen by the request generator

    task automatic queue_req(logic [1:0] op, logic [bhpq_pkg::KEY_W-1:0] key,
                             int unsigned s);
        heap_req_t r;
        r.op   = op;
        r.key  = key;
        r.slot = bhpq_pkg::CNT_W'(s);
        req_pending.insert(req_pending.size(), r);
        if (op == bhpq_pkg::MODE_PUSH && gen_cnt < bhpq_pkg::CAPACITY)
            gen_cnt++;
        else if (op == bhpq_pkg::MODE_POP && gen_cnt > 0)
            gen_cnt--;
    endtask

    function automatic logic [bhpq_pkg::KEY_W-1:0] rand_key();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return bhpq_pkg::KEY_W'($urandom_range(15));   // many ties
            default: return $urandom;
        endcase
    endfunction

    function automatic int unsigned rand_slot();
        case ($urandom_range(19))
            0:       return 0;
            1:       return gen_cnt + 1;
            2:       return $urandom_range(2047);
            3:       return 1;
            4:       return gen_cnt;
            default: return (gen_cnt > 0) ? $urandom_range(gen_cnt, 1) : 0;
        endcase
    endfunction

    task automatic run_mix(int n, int push_w, int pop_w);
        int p;
        for (int i = 0; i < n; i++)
        begin
            p = $urandom_range(99);
            if (p < 2)
                queue_req(MODE_UNUSED, $urandom, $urandom_range(2047));
            else if (p < 2 + push_w)
                queue_req(bhpq_pkg::MODE_PUSH, rand_key(), $urandom_range(2047));
            else if (p < 2 + push_w + pop_w)
                queue_req(bhpq_pkg::MODE_POP, $urandom, $urandom_range(2047));
            else
                queue_req(bhpq_pkg::MODE_UPDATE, rand_key(), rand_slot());
        end
    endtask

    // holds until the block has answered every request, plus a margin
    task automatic wait_heap_quiet();
        do
            @(negedge clk);
        while (req_pending.size() != 0 || start || heap_expect.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_order(bit v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        order_min = v;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_order(1'b1);
        idle_pct = 32;

        // directed: empty cases, extremes, ties, each update path
        queue_req(bhpq_pkg::MODE_POP, '1, 2047);
        queue_req(bhpq_pkg::MODE_UPDATE, '1, 0);
        queue_req(bhpq_pkg::MODE_UPDATE, '1, 1);
        queue_req(MODE_UNUSED, '1, 2047);
        queue_req(bhpq_pkg::MODE_PUSH, '1, 0);
        queue_req(bhpq_pkg::MODE_PUSH, '0, 2047);
        queue_req(bhpq_pkg::MODE_PUSH, 32'd5, 0);
        queue_req(bhpq_pkg::MODE_PUSH, 32'd5, 0);
        queue_req(bhpq_pkg::MODE_PUSH, 32'h8000_0000, 0);
        queue_req(bhpq_pkg::MODE_PUSH, 32'd3, 0);
        queue_req(bhpq_pkg::MODE_UPDATE, '1, 1);              // root sinks
        queue_req(bhpq_pkg::MODE_UPDATE, '0, 6);              // leaf rises
        queue_req(bhpq_pkg::MODE_UPDATE, 32'd7, 2);           // inner slot
        queue_req(bhpq_pkg::MODE_UPDATE, 32'd1, 7);           // one past count
        queue_req(bhpq_pkg::MODE_UPDATE, 32'd1, 1024);
        queue_req(bhpq_pkg::MODE_UPDATE, 32'd1, 2047);
        queue_req(bhpq_pkg::MODE_UPDATE, 32'd1, 0);
        queue_req(MODE_UNUSED, '0, 1);
        queue_req(bhpq_pkg::MODE_POP, '0, 0);
        queue_req(bhpq_pkg::MODE_POP, '0, 0);
        queue_req(bhpq_pkg::MODE_POP, '0, 0);
        queue_req(bhpq_pkg::MODE_PUSH, 32'd1, 0);
        repeat (5) queue_req(bhpq_pkg::MODE_POP, '0, 0);      // drains, last one on empty
        wait_heap_quiet();

        run_mix(300, 50, 35);
        wait_heap_quiet();

        // order flips with keys stored
        write_order(1'b0);
        idle_pct = 65;
        run_mix(300, 35, 45);
        wait_heap_quiet();

        write_order(1'b1);
        idle_pct = 0;
        while (gen_cnt < bhpq_pkg::CAPACITY)
            queue_req(bhpq_pkg::MODE_PUSH, rand_key(), $urandom_range(2047));
        repeat (4) queue_req(bhpq_pkg::MODE_PUSH, rand_key(), 0);
        queue_req(bhpq_pkg::MODE_UPDATE, '0, bhpq_pkg::CAPACITY);
        queue_req(bhpq_pkg::MODE_UPDATE, '1, bhpq_pkg::CAPACITY + 1);
        run_mix(150, 45, 45);
        wait_heap_quiet();

        write_order(1'b0);
        run_mix(100, 45, 45);
        wait_heap_quiet();

        if (mismatch_cnt == 0 && heap_expect.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### filelist.f
rtl/core/bhpq_pkg.sv
rtl/core/bhpq_ram.sv
rtl/core/bhpq_cmp.sv
rtl/core/bhpq_ctrl.sv
rtl/core/binary_heap_priority_queue.sv
test/tb_binary_heap_priority_queue.sv
